/* hw/rtl/packet_drop_fault_injector_assert.svh */
// Assertion macros for the packet drop fault injector checker
`ifndef PACKET_DROP_FAULT_INJECTOR_ASSERT_SVH
`define PACKET_DROP_FAULT_INJECTOR_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define PDFI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define PDFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/pdfi_pkg.sv */
// Package: types, codes and helpers for the packet drop fault injector
`timescale 1ns / 1ps
`default_nettype none
package pdfi_pkg;
    localparam int RULES = 8;
    localparam int IDX_W = $clog2(RULES);

    localparam logic [2:0] FUNC_ADD   = 3'd0;
    localparam logic [2:0] FUNC_DEL   = 3'd1;
    localparam logic [2:0] FUNC_DELALL = 3'd2;
    localparam logic [2:0] FUNC_LIST  = 3'd3;
    localparam logic [2:0] FUNC_CHECK = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RATE     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [2:0] MT_PUT   = 3'd0;
    localparam logic [2:0] MT_ACK   = 3'd1;
    localparam logic [2:0] MT_GET   = 3'd2;
    localparam logic [2:0] MT_REPLY = 3'd3;

    localparam logic [63:0] NID_ANY = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] ADDR_ANY = 32'hFFFF_FFFF;
    localparam logic [31:0] DROP_RATE_MIN = 32'd1;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] src_nid;
        logic [63:0] dst_nid;
        logic [31:0] rate;
        logic [31:0] delay;
        logic [2:0]  pos;
        logic [2:0]  msg_kind;
        logic [31:0] now_sec;
        logic [31:0] random;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        drop_flag;
        logic [3:0]  removed_count;
        logic [63:0] listed_src;
        logic [63:0] listed_dst;
        logic [31:0] listed_rate;
        logic [31:0] listed_put_drops;
        logic [31:0] listed_ack_drops;
        logic [31:0] listed_get_drops;
        logic [31:0] listed_reply_drops;
    } t_out;

    // One rule entry as held in memory
    typedef struct packed {
        logic [63:0] src;
        logic [63:0] dst;
        logic [31:0] rate;
        logic [31:0] drop_at;
        logic [31:0] count;
        logic [31:0] start;
        logic [31:0] put_d;
        logic [31:0] ack_d;
        logic [31:0] get_d;
        logic [31:0] reply_d;
    } t_rule;

    // Divider handshake between top level and remainder unit
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_div_rsp;

    function automatic logic id_match(input logic [63:0] r, input logic [63:0] n);
        logic m;
        if (r == NID_ANY) m = 1'b1;
        else if (r[63:32] != n[63:32]) m = 1'b0;
        else m = (r[31:0] == ADDR_ANY) || (r == n);
        return m;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/pdfi_rem.sv */
// Iterative 32-bit remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pdfi_rem (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pdfi_pkg::t_div_req  i_req,
    output pdfi_pkg::t_div_rsp  o_rsp
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_num;
    logic [31:0] r_den;
    logic [32:0] r_rem;
    logic        r_done;
    logic [32:0] shifted;
    logic [32:0] diff;

    // restoring step
    assign shifted = {r_rem[31:0], r_num[31]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= diff[32] ? shifted : diff;
                r_num <= {r_num[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[31:0];
endmodule
`default_nettype wire

/* hw/rtl/packet_drop_fault_injector.sv */
// Top level: rule memory, scan sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
// Delete, list and a check with no active match scan every rule slot. An accepted add
// skips the scan and runs one remainder (random % rate); an active check scans, then
// runs (count + 1) % rate, and random % rate too when it refills its window. Rejected
// adds and unknown functions answer with no scan. One item at a time: the next item
// is taken the cycle after the result transfer.
// Reset clears valid bits, ages and min_rate (to 1); rule memory stays undefined.
module packet_drop_fault_injector (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  pdfi_pkg::t_in     i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output pdfi_pkg::t_out    o_data,
    input  wire               i_cfg_we,
    input  wire [31:0]        i_cfg_data
);
    localparam int W = pdfi_pkg::IDX_W;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_WRITE, S_DONE} t_state;
    // check sub-steps after the scan
    typedef enum logic [1:0] {STEP_NONE, STEP_CNT, STEP_RAND, STEP_WB} t_step;

    t_state               r_state;
    t_step                r_step;
    pdfi_pkg::t_in        r_in;
    logic [31:0]          r_min_rate;
    logic [pdfi_pkg::RULES-1:0] r_valid;
    logic [W-1:0]         r_age [pdfi_pkg::RULES];
    pdfi_pkg::t_rule      r_mem [pdfi_pkg::RULES];
    pdfi_pkg::t_rule      r_rd;
    logic [W:0]           r_idx;
    logic                 r_rd_vld;
    logic [W-1:0]         r_rd_idx;
    logic                 r_hit;
    logic [W-1:0]         r_hit_idx;
    pdfi_pkg::t_rule      r_hit_rule;
    logic [3:0]           r_removed;
    logic [pdfi_pkg::RULES-1:0] r_kill;
    logic                 r_drop;
    pdfi_pkg::t_rule      r_wr;
    logic                 r_do_wr;
    pdfi_pkg::t_div_req   r_div;
    pdfi_pkg::t_div_rsp   div_rsp;
    logic [W-1:0]         free_idx;
    logic                 free_ok;
    logic                 rd_match;
    logic [31:0]          eff_rate;
    logic [31:0]          cnt_inc;

    pdfi_rem u_rem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_div),
        .o_rsp  (div_rsp)
    );

    // first free slot
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int k = pdfi_pkg::RULES - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = W'(k);
                free_ok  = 1'b1;
            end
        end
    end

    // per-entry test on the word just read
    always_comb begin
        rd_match = 1'b0;
        case (r_in.func)
            pdfi_pkg::FUNC_DEL:
                rd_match = (r_rd.src == r_in.src_nid) && (r_rd.dst == r_in.dst_nid);
            pdfi_pkg::FUNC_DELALL: rd_match = 1'b1;
            pdfi_pkg::FUNC_LIST:
                rd_match = ({1'b0, r_age[r_rd_idx]} == {1'b0, r_in.pos});
            pdfi_pkg::FUNC_CHECK:
                rd_match = pdfi_pkg::id_match(r_rd.src, r_in.src_nid)
                        && pdfi_pkg::id_match(r_rd.dst, r_in.dst_nid)
                        && (!r_hit || r_age[r_rd_idx] < r_age[r_hit_idx]);
            default: rd_match = 1'b0;
        endcase
    end

    assign eff_rate = (r_hit_rule.rate != 32'd0) ? r_hit_rule.rate : 32'd1;
    assign cnt_inc  = r_hit_rule.count + 32'd1;
    assign o_ready  = (r_state == S_IDLE) && !o_valid;

    // rule memory: registered read, single write port
    always_ff @(posedge i_clk) begin
        if (r_do_wr) r_mem[r_hit_idx] <= r_wr;
        r_rd <= r_mem[r_idx[W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= STEP_NONE;
            r_min_rate <= pdfi_pkg::DROP_RATE_MIN;
            r_valid    <= '0;
            for (int k = 0; k < pdfi_pkg::RULES; k++) r_age[k] <= '0;
            o_valid    <= 1'b0;
            r_do_wr    <= 1'b0;
            r_div      <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_do_wr     <= 1'b0;
            r_div.start <= 1'b0;
            if (i_cfg_we) r_min_rate <= i_cfg_data;
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in      <= i_data;
                        o_data    <= '0;
                        r_hit     <= 1'b0;
                        r_removed <= '0;
                        r_kill    <= '0;
                        r_drop    <= 1'b0;
                        r_idx     <= '0;
                        r_rd_vld  <= 1'b0;
                        r_step    <= STEP_NONE;
                        case (i_data.func)
                            pdfi_pkg::FUNC_ADD: begin
                                if (i_data.rate == 32'd0 || i_data.rate < r_min_rate) begin
                                    o_data.status <= pdfi_pkg::ST_RATE;
                                    r_state <= S_DONE;
                                end else if (!free_ok) begin
                                    o_data.status <= pdfi_pkg::ST_FULL;
                                    r_state <= S_DONE;
                                end else begin
                                    r_hit_idx   <= free_idx;
                                    r_div.start <= 1'b1;
                                    r_div.num   <= i_data.random;
                                    r_div.den   <= i_data.rate;
                                    r_state     <= S_DIV;
                                end
                            end
                            pdfi_pkg::FUNC_DEL, pdfi_pkg::FUNC_DELALL,
                            pdfi_pkg::FUNC_LIST, pdfi_pkg::FUNC_CHECK:
                                r_state <= S_SCAN;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                // one entry read per cycle; evaluate the previous read
                S_SCAN: begin
                    r_rd_vld <= (r_idx < (W+1)'(pdfi_pkg::RULES))
                             && r_valid[r_idx[W-1:0]];
                    r_rd_idx <= r_idx[W-1:0];
                    r_idx    <= r_idx + 1'b1;
                    if (r_rd_vld && rd_match) begin
                        case (r_in.func)
                            pdfi_pkg::FUNC_DEL, pdfi_pkg::FUNC_DELALL: begin
                                r_kill[r_rd_idx] <= 1'b1;
                                r_removed <= r_removed + 4'd1;
                            end
                            default: begin
                                if (!(r_in.func == pdfi_pkg::FUNC_LIST && r_hit)) begin
                                    r_hit      <= 1'b1;
                                    r_hit_idx  <= r_rd_idx;
                                    r_hit_rule <= r_rd;
                                end
                            end
                        endcase
                    end
                    if (r_idx == (W+1)'(pdfi_pkg::RULES)) r_state <= S_WRITE;
                end
                // add goes on to the write; check steps resume in S_DONE
                S_DIV: begin
                    if (div_rsp.done) r_state <= (r_step == STEP_NONE) ? S_WRITE : S_DONE;
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                    case (r_in.func)
                        pdfi_pkg::FUNC_ADD: begin
                            for (int k = 0; k < pdfi_pkg::RULES; k++)
                                if (r_valid[k]) r_age[k] <= r_age[k] + 1'b1;
                            r_age[r_hit_idx]   <= '0;
                            r_valid[r_hit_idx] <= 1'b1;
                            r_wr.src     <= r_in.src_nid;
                            r_wr.dst     <= r_in.dst_nid;
                            r_wr.rate    <= r_in.rate;
                            r_wr.drop_at <= div_rsp.rem;
                            r_wr.count   <= '0;
                            r_wr.start   <= (r_in.delay != 32'd0)
                                          ? r_in.now_sec + r_in.delay : 32'd0;
                            r_wr.put_d   <= '0;
                            r_wr.ack_d   <= '0;
                            r_wr.get_d   <= '0;
                            r_wr.reply_d <= '0;
                            r_do_wr      <= 1'b1;
                        end
                        pdfi_pkg::FUNC_DEL, pdfi_pkg::FUNC_DELALL: begin
                            // surviving rules drop one age step per removed newer rule
                            for (int k = 0; k < pdfi_pkg::RULES; k++) begin
                                automatic logic [W:0] dec = '0;
                                for (int j = 0; j < pdfi_pkg::RULES; j++)
                                    if (r_kill[j] && r_valid[j] && r_age[j] < r_age[k])
                                        dec = dec + 1'b1;
                                r_age[k] <= W'({1'b0, r_age[k]} - dec);
                            end
                            r_valid <= r_valid & ~r_kill;
                            o_data.removed_count <= r_removed;
                        end
                        pdfi_pkg::FUNC_LIST: begin
                            if (!r_hit) o_data.status <= pdfi_pkg::ST_NOTFOUND;
                            else begin
                                o_data.listed_src         <= r_hit_rule.src;
                                o_data.listed_dst         <= r_hit_rule.dst;
                                o_data.listed_rate        <= r_hit_rule.rate;
                                o_data.listed_put_drops   <= r_hit_rule.put_d;
                                o_data.listed_ack_drops   <= r_hit_rule.ack_d;
                                o_data.listed_get_drops   <= r_hit_rule.get_d;
                                o_data.listed_reply_drops <= r_hit_rule.reply_d;
                            end
                        end
                        default: begin
                            // check: first pass computes (count + 1) % rate, second refills when that is zero
                            if (r_hit && !(r_hit_rule.start != 32'd0
                                           && r_hit_rule.start > r_in.now_sec)) begin
                                r_drop      <= (r_hit_rule.count == r_hit_rule.drop_at);
                                r_div.start <= 1'b1;
                                r_div.num   <= cnt_inc;
                                r_div.den   <= eff_rate;
                                r_step      <= STEP_CNT;
                                r_state     <= S_DIV;
                            end
                        end
                    endcase
                end
                S_DONE: begin
                    case (r_step)
                        STEP_CNT: begin
                            // (count + 1) % rate is ready; launch random % rate if refilling
                            r_hit_rule.count <= cnt_inc;
                            if (r_drop) begin
                                case (r_in.msg_kind)
                                    pdfi_pkg::MT_PUT:
                                        r_hit_rule.put_d <= r_hit_rule.put_d + 32'd1;
                                    pdfi_pkg::MT_ACK:
                                        r_hit_rule.ack_d <= r_hit_rule.ack_d + 32'd1;
                                    pdfi_pkg::MT_GET:
                                        r_hit_rule.get_d <= r_hit_rule.get_d + 32'd1;
                                    pdfi_pkg::MT_REPLY:
                                        r_hit_rule.reply_d <= r_hit_rule.reply_d + 32'd1;
                                    default: ;
                                endcase
                                o_data.drop_flag <= 1'b1;
                            end
                            if (div_rsp.rem == 32'd0) begin
                                r_div.start <= 1'b1;
                                r_div.num   <= r_in.random;
                                r_div.den   <= eff_rate;
                                r_step      <= STEP_RAND;
                                r_state     <= S_DIV;
                            end else begin
                                r_step <= STEP_WB;
                            end
                        end
                        STEP_RAND: begin
                            r_hit_rule.drop_at <= r_hit_rule.count + div_rsp.rem;
                            r_step <= STEP_WB;
                        end
                        STEP_WB: begin
                            r_wr    <= r_hit_rule;
                            r_do_wr <= 1'b1;
                            o_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        default: begin
                            o_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/pdfi_checker.sv */
// Port-level checker for the packet drop fault injector, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "packet_drop_fault_injector_assert.svh"
module pdfi_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_valid,
    input wire             o_ready,
    input wire             o_valid,
    input wire             i_ready,
    input pdfi_pkg::t_out  o_data
);
    `PDFI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `PDFI_ASSERT_IMP(a_no_accept_while_out, i_clk, i_rst_n, o_valid, !o_ready)
    `PDFI_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `PDFI_ASSERT_IMP(a_drop_clean, i_clk, i_rst_n, o_valid && o_data.drop_flag, o_data.status == pdfi_pkg::ST_OK && o_data.removed_count == 4'd0)
endmodule
bind packet_drop_fault_injector pdfi_checker u_pdfi_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);
`default_nettype wire
